// ===== design/ssst_pkg.sv =====
package ssst_pkg;

   // Number of cells in the row (2 to 64).
   localparam int unsigned CAPACITY = 16;
   localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic {
      KIND_ADD    = 1'b0,
      KIND_DELETE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      OUT_ADDED    = 3'd0,
      OUT_PRESENT  = 3'd1,
      OUT_DROPPED  = 3'd2,
      OUT_DELETED  = 3'd3,
      OUT_NOTFOUND = 3'd4
   } outcome_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      outcome_type outcome;
      logic [4:0]  member_count;
      logic        is_full;
      logic        is_empty;
   } rsp_type;

   // Top level to cell row: what the accepted request does to the set.
   typedef struct packed {
      logic add_go;
      logic del_go;
   } chain_ctl_type;

   // Cell row to one cell.
   typedef struct packed {
      logic occupied;
      logic append;
      logic remove;
   } cell_ctl_type;

endpackage

// ===== design/ssst_cell.sv =====
module ssst_cell (
   input  logic                  clock,
   input  logic [7:0]            symbol,
   input  ssst_pkg::cell_ctl_type ctl,
   input  logic [7:0]            next_slot,
   input  logic                  hit_in,
   output logic                  hit_out,
   output logic [7:0]            slot
);

   logic [7:0] slot_ff;
   logic [7:0] slot_in;
   logic       match;

   assign match   = ctl.occupied && (slot_ff == symbol);
   assign hit_out = hit_in | match;
   assign slot    = slot_ff;

   // Load a new member, or take the neighbor's entry when a member at or
   // below this place leaves.
   always_comb begin
      slot_in = slot_ff;
      if (ctl.append) begin
         slot_in = symbol;
      end else if (ctl.remove && hit_out) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== design/ssst_chain.sv =====
module ssst_chain (
   input  logic                         clock,
   input  logic [7:0]                   symbol,
   input  logic [ssst_pkg::CNT_W-1:0]   total,
   input  ssst_pkg::chain_ctl_type      ctl,
   output logic                         hit
);

   logic [7:0]                   slot_w  [ssst_pkg::CAPACITY];
   logic [ssst_pkg::CAPACITY:0]  hit_chain;

   assign hit_chain[0] = 1'b0;
   assign hit          = hit_chain[ssst_pkg::CAPACITY];

   for (genvar i = 0; i < ssst_pkg::CAPACITY; i++) begin : g_cell
      localparam logic [ssst_pkg::CNT_W-1:0] Idx = ssst_pkg::CNT_W'(i);
      ssst_pkg::cell_ctl_type cell_ctl;
      logic [7:0]             next_slot;

      assign cell_ctl.occupied = (total > Idx);
      assign cell_ctl.append   = ctl.add_go && (total == Idx);
      assign cell_ctl.remove   = ctl.del_go;

      // The last cell has no neighbor; what it keeps lies past the count.
      if (i == ssst_pkg::CAPACITY - 1) begin : g_last
         assign next_slot = slot_w[i];
      end else begin : g_mid
         assign next_slot = slot_w[i+1];
      end

      ssst_cell u_cell (
         .clock     (clock),
         .symbol    (symbol),
         .ctl       (cell_ctl),
         .next_slot (next_slot),
         .hit_in    (hit_chain[i]),
         .hit_out   (hit_chain[i+1]),
         .slot      (slot_w[i])
      );
   end

endmodule

// ===== design/small_symbol_set_table_core.sv =====
// Packed set of up to ssst_pkg::CAPACITY byte symbols in insertion order, built
// as a row of cells, one member per cell. An add request appends a new symbol
// to the first free cell, reports a duplicate as already present, and drops a
// new symbol when the set is full. A delete request removes the matching
// member; that cell and every cell above it take their upper neighbor's entry
// in the same cycle, so the set stays packed. Each request gives exactly one
// response: outcome, member count after the request (low 5 bits), and full and
// empty flags. Throughput is one request per clock unless the response stalls:
// every cell compares its entry against the symbol at once and the match
// ripples up the row as a prefix OR, so the whole update is combinational. The
// response is registered and appears in the cycle after acceptance; req_ready
// stays high while the response register is empty or being taken, so a stalled
// response holds back only the next request. No clearing pass is needed after
// reset: cells are not reset, and cells above the count are never compared.
module small_symbol_set_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ssst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ssst_pkg::rsp_type rsp_data
);

   localparam logic [ssst_pkg::CNT_W-1:0] CapCount = ssst_pkg::CNT_W'(ssst_pkg::CAPACITY);

   logic [ssst_pkg::CNT_W-1:0]   total_ff;
   logic [ssst_pkg::CNT_W-1:0]   total_in;
   logic [ssst_pkg::CNT_W+4:0]   total_wide;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ssst_pkg::rsp_type            rsp_data_ff;
   ssst_pkg::rsp_type            rsp_data_in;
   ssst_pkg::outcome_type        outcome;
   ssst_pkg::chain_ctl_type      chain_ctl;
   logic                         accept;
   logic                         hit;
   logic                         full;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (total_ff == CapCount);

   ssst_chain u_chain (
      .clock  (clock),
      .symbol (req_data.symbol),
      .total  (total_ff),
      .ctl    (chain_ctl),
      .hit    (hit)
   );

   // Decide the outcome and the new count; the duplicate check comes first.
   always_comb begin
      outcome           = ssst_pkg::OUT_NOTFOUND;
      total_in          = total_ff;
      chain_ctl.add_go  = 1'b0;
      chain_ctl.del_go  = 1'b0;
      case (req_data.kind)
         ssst_pkg::KIND_ADD: begin
            if (hit) begin
               outcome = ssst_pkg::OUT_PRESENT;
            end else if (full) begin
               outcome = ssst_pkg::OUT_DROPPED;
            end else begin
               outcome          = ssst_pkg::OUT_ADDED;
               total_in         = total_ff + 1'b1;
               chain_ctl.add_go = accept;
            end
         end
         ssst_pkg::KIND_DELETE: begin
            if (hit) begin
               outcome          = ssst_pkg::OUT_DELETED;
               total_in         = total_ff - 1'b1;
               chain_ctl.del_go = accept;
            end
         end
         default: begin
            outcome = ssst_pkg::OUT_NOTFOUND;
         end
      endcase
   end

   // Count field shows only the low 5 bits of the member count.
   assign total_wide = {5'd0, total_in};

   always_comb begin
      rsp_data_in.outcome      = outcome;
      rsp_data_in.member_count = total_wide[4:0];
      rsp_data_in.is_full      = (total_in == CapCount);
      rsp_data_in.is_empty     = (total_in == '0);
   end

   // Hold the response until taken; a new request may refill it the same cycle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CapCount)
      else $error("member count above capacity");

   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(total_ff))
      else $error("member count changed without a request");

   a_delete_dec: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == ssst_pkg::KIND_DELETE && hit
      |=> total_ff + 1'b1 == $past(total_ff))
      else $error("delete of a member did not drop the count by one");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_added_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.outcome == ssst_pkg::OUT_ADDED |-> !rsp_data_ff.is_empty)
      else $error("added response reports an empty set");
`endif

endmodule

// ===== test/tb_small_symbol_set_table_core.sv =====
module tb_small_symbol_set_table_core;

   import ssst_pkg::*;

   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is a random idle or stall run at 75 percent, which
   // stays far below this.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles to keep watching after the last response, for stray responses.
   localparam int DRAIN_CYCLES   = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predicted contents of the set, packed in insertion order.
   logic [7:0] set_slots [CAPACITY];
   int         set_total = 0;

   rsp_type    predicted_rsps [$];
   int         send_idle_pct  = 0;
   int         recv_stall_pct = 0;
   int         sent_count     = 0;
   int         checked_count  = 0;
   int         fail_count     = 0;
   int         quiet_cycles   = 0;
   int         outcome_hits [5] = '{default: 0};

   small_symbol_set_table_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Apply one accepted request to the predicted set and return the response
   // it must produce.
   function automatic rsp_type apply_request(req_type r);
      rsp_type res;
      int      found;
      res   = '0;
      found = -1;
      for (int i = 0; i < set_total; i++) begin
         if (found < 0 && set_slots[i] == r.symbol) found = i;
      end
      if (r.kind == KIND_ADD) begin
         // Duplicate check comes first, so a present symbol wins over full.
         if (found >= 0) begin
            res.outcome = OUT_PRESENT;
         end else if (set_total >= CAPACITY) begin
            res.outcome = OUT_DROPPED;
         end else begin
            set_slots[set_total] = r.symbol;
            set_total++;
            res.outcome = OUT_ADDED;
         end
      end else if (found >= 0) begin
         // Close the gap: every later member moves down one slot.
         for (int j = found; j + 1 < set_total; j++) set_slots[j] = set_slots[j + 1];
         set_total--;
         res.outcome = OUT_DELETED;
      end else begin
         res.outcome = OUT_NOTFOUND;
      end
      // Count shows only its low 5 bits; the flags follow the full count.
      res.member_count = 5'(set_total);
      res.is_full      = (set_total >= CAPACITY);
      res.is_empty     = (set_total == 0);
      outcome_hits[int'(res.outcome)]++;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR at response %0d: %s got %0d want %0d", checked_count, what, got, want);
      fail_count++;
   endtask

   // Offer one request, idling first at the phase's rate, and hold it until
   // the block takes it.
   task automatic send_request(kind_type kind, logic [7:0] symbol);
      req_type item;
      item.kind   = kind;
      item.symbol = symbol;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Randomize the response side stall each cycle at the phase's rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Predict on every accepted request, then check every accepted response
   // against the oldest prediction. Handle the request first so a response
   // in the same cycle would still find its prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) predicted_rsps.push_back(apply_request(req_data));
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch("response with no request pending", 1, 0);
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_data.outcome !== want.outcome)
                  report_mismatch("outcome", rsp_data.outcome, want.outcome);
               if (rsp_data.member_count !== want.member_count)
                  report_mismatch("member_count", rsp_data.member_count, want.member_count);
               if (rsp_data.is_full !== want.is_full)
                  report_mismatch("is_full", rsp_data.is_full, want.is_full);
               if (rsp_data.is_empty !== want.is_empty)
                  report_mismatch("is_empty", rsp_data.is_empty, want.is_empty);
            end
            checked_count++;
         end
         // Any handshake counts as progress; otherwise advance the watchdog.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, predicted_rsps.size());
            $display("small_symbol_set_table_core: mismatch");
            $finish;
         end
      end
   end

   // Walk the corners from an empty set: delete while empty, extreme symbols,
   // duplicate add, fill to capacity, drop while full, duplicate while full,
   // and deletes at the middle, front and back of the row.
   task automatic test_directed();
      send_request(KIND_DELETE, 8'h55);
      send_request(KIND_ADD, 8'h00);
      send_request(KIND_ADD, 8'hFF);
      send_request(KIND_ADD, 8'h00);
      for (int i = 1; i <= CAPACITY - 2; i++) send_request(KIND_ADD, 8'(i));
      send_request(KIND_ADD, 8'hAA);
      send_request(KIND_ADD, 8'd7);
      send_request(KIND_DELETE, 8'd7);
      send_request(KIND_DELETE, 8'h00);
      send_request(KIND_DELETE, 8'(CAPACITY - 2));
      send_request(KIND_DELETE, 8'(CAPACITY - 2));
      send_request(KIND_ADD, 8'hAA);
   endtask

   // Empty the set in random order, fill it past capacity, then drain it
   // with a mix of hits and misses.
   task automatic test_fill_and_drain();
      logic [7:0] members [$];
      logic [7:0] base;
      int         pick;
      // Let the last request settle into the prediction before reading it.
      req_valid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < set_total; i++) members.push_back(set_slots[i]);
      while (members.size() != 0) begin
         pick = $urandom_range(members.size() - 1);
         send_request(KIND_DELETE, members[pick]);
         members.delete(pick);
      end
      base = 8'($urandom_range(255));
      for (int i = 0; i < CAPACITY + 4; i++) send_request(KIND_ADD, 8'(base + i));
      for (int i = 0; i < 4; i++) send_request(KIND_ADD, 8'(base + $urandom_range(CAPACITY + 3)));
      for (int i = 0; i < 2 * CAPACITY; i++)
         send_request(KIND_DELETE, 8'(base + $urandom_range(CAPACITY + 3)));
      for (int i = 0; i < CAPACITY + 4; i++) send_request(KIND_DELETE, 8'(base + i));
   endtask

   // Alternate add-heavy and delete-heavy blocks over a small symbol pool so
   // the set swings between full and empty; a tenth of the symbols are noise
   // from the whole byte range.
   task automatic test_random_mix(int count);
      int         add_pct;
      bit         add_heavy;
      logic [7:0] base;
      logic [7:0] symbol;
      kind_type   kind;
      add_pct   = 80;
      add_heavy = 1'b0;
      base      = '0;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            add_heavy = !add_heavy;
            add_pct   = add_heavy ? 80 : 25;
            base      = 8'($urandom_range(255));
         end
         kind = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_DELETE;
         if ($urandom_range(9) == 0) begin
            symbol = 8'($urandom_range(255));
         end else begin
            symbol = 8'(base + $urandom_range(CAPACITY + 3));
         end
         send_request(kind, symbol);
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      test_fill_and_drain();
      test_random_mix(230);
   endtask

   initial begin
      // Hold reset, then release it at a rising edge.
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      // Idle phases: none, sender idle, receiver stall, both lightly.
      run_phase(0, 0);
      run_phase(75, 0);
      run_phase(0, 75);
      run_phase(12, 12);

      // Drop valid, let the last request reach the prediction queue, drain
      // the outstanding responses, then keep watching for anything unexpected.
      // The watchdog covers a hang here.
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests over four idle phases, %0d responses checked",
               sent_count, checked_count);
      $display("outcomes: added %0d, present %0d, dropped %0d, deleted %0d, not found %0d",
               outcome_hits[OUT_ADDED], outcome_hits[OUT_PRESENT], outcome_hits[OUT_DROPPED],
               outcome_hits[OUT_DELETED], outcome_hits[OUT_NOTFOUND]);
      if (fail_count == 0) begin
         $display("small_symbol_set_table_core: match");
      end else begin
         $display("small_symbol_set_table_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ssst_pkg.sv
design/ssst_cell.sv
design/ssst_chain.sv
design/small_symbol_set_table_core.sv
test/tb_small_symbol_set_table_core.sv
